FILE: design/bmf_pkg.sv
// ----------------------------------------------------------------------------
// bmf_pkg
// Types, codes and constants shared by the biased matrix-factorization
// SGD block: request/result words, queue entries and sequencer states.
// ----------------------------------------------------------------------------
package bmf_pkg;

  localparam int MAX_USERS_DEF   = 1024;
  localparam int MAX_ITEMS_DEF   = 1024;
  localparam int NUM_FACTORS_DEF = 9;

  // factor base address: id * NUM_FACTORS at the largest legal sizes
  localparam int BASE_W      = 22;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [15:0] GLOBAL_AVG_RST   = 16'd0;
  localparam logic [15:0] LEARN_RATE_RST   = 16'd983;
  localparam logic [15:0] REG_STRENGTH_RST = 16'd6554;
  localparam logic [10:0] COUNT_RST        = 11'd0;

  // clamp bounds of the prediction, Q24.24
  localparam logic signed [47:0] PRED_LO = 48'sh0000_0100_0000;
  localparam logic signed [47:0] PRED_HI = 48'sh0000_0500_0000;

  typedef enum logic [1:0] {
    RT_TRAIN      = 2'd0,
    RT_PREDICT    = 2'd1,
    RT_LOAD_USER  = 2'd2,
    RT_LOAD_ITEM  = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_OOR    = 2'd1,
    ST_LOADED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CFG_GLOBAL_AVG   = 3'd0,
    CFG_LEARN_RATE   = 3'd1,
    CFG_REG_STRENGTH = 3'd2,
    CFG_USER_COUNT   = 3'd3,
    CFG_ITEM_COUNT   = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    K_TRAIN,
    K_PREDICT,
    K_LOAD_U,
    K_LOAD_I,
    K_REJECT
  } kind_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_LOAD,
    B_BRD,
    B_BACC,
    B_DRD,
    B_DMUL,
    B_DACC,
    B_PRED,
    B_ERR,
    B_URD,
    B_UM1,
    B_UM2,
    B_UWR,
    B_OUT
  } back_state_t;

  typedef struct packed {
    req_type_t          req_type;
    logic [15:0]        user_id;
    logic [15:0]        item_id;
    logic [15:0]        rating;
    logic [5:0]         factor_index;
    logic signed [31:0] factor_value;
  } req_t;

  typedef struct packed {
    logic [15:0] prediction;
    status_t     status;
  } rsp_t;

  typedef struct packed {
    logic [15:0] global_avg;
    logic [15:0] learn_rate;
    logic [15:0] reg_strength;
    logic [10:0] user_count;
    logic [10:0] item_count;
  } cfg_t;

  typedef struct packed {
    kind_t              kind;
    logic [15:0]        uid;
    logic [15:0]        iid;
    logic [BASE_W-1:0]  ubase;
    logic [BASE_W-1:0]  ibase;
    logic [15:0]        rating;
    logic [5:0]         fidx;
    logic signed [31:0] fval;
    logic [15:0]        rej_pred;
  } entry_t;

  function automatic logic signed [31:0] sat32(input logic signed [40:0] x);
    logic signed [31:0] r;
    if (x[40:31] == '0 || x[40:31] == '1) begin
      r = x[31:0];
    end else if (x[40]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

FILE: design/bmf_front.sv
// ----------------------------------------------------------------------------
// bmf_front
// Accepts request words, checks ids and factor index, and turns each into
// a queue entry with its factor base addresses precomputed.
// ----------------------------------------------------------------------------
module bmf_front #(
  parameter int MAX_USERS   = bmf_pkg::MAX_USERS_DEF,
  parameter int MAX_ITEMS   = bmf_pkg::MAX_ITEMS_DEF,
  parameter int NUM_FACTORS = bmf_pkg::NUM_FACTORS_DEF
) (
  input  logic            req_valid,
  input  bmf_pkg::req_t   req,
  output logic            req_stall,
  input  bmf_pkg::cfg_t   cfg,
  input  logic            q_full,
  input  logic            clearing,
  output logic            push,
  output bmf_pkg::entry_t entry
);

  logic uid_mem_ok, iid_mem_ok, uid_ok, iid_ok, fidx_ok;

  always_comb begin
    uid_mem_ok = {1'b0, req.user_id} < 17'(MAX_USERS);
    iid_mem_ok = {1'b0, req.item_id} < 17'(MAX_ITEMS);
    uid_ok     = uid_mem_ok && (req.user_id < {5'b0, cfg.user_count});
    iid_ok     = iid_mem_ok && (req.item_id < {5'b0, cfg.item_count});
    fidx_ok    = {1'b0, req.factor_index} < 7'(NUM_FACTORS);
  end

  always_comb begin
    entry.uid      = req.user_id;
    entry.iid      = req.item_id;
    entry.ubase    = bmf_pkg::BASE_W'(req.user_id) * bmf_pkg::BASE_W'(NUM_FACTORS);
    entry.ibase    = bmf_pkg::BASE_W'(req.item_id) * bmf_pkg::BASE_W'(NUM_FACTORS);
    entry.rating   = req.rating;
    entry.fidx     = req.factor_index;
    entry.fval     = req.factor_value;
    entry.rej_pred = '0;
    entry.kind     = bmf_pkg::K_REJECT;
    unique case (req.req_type)
      bmf_pkg::RT_TRAIN, bmf_pkg::RT_PREDICT: begin
        if (uid_ok && iid_ok) begin
          entry.kind = (req.req_type == bmf_pkg::RT_TRAIN) ? bmf_pkg::K_TRAIN
                                                           : bmf_pkg::K_PREDICT;
        end else begin
          entry.rej_pred = cfg.global_avg;
        end
      end
      bmf_pkg::RT_LOAD_USER: begin
        if (uid_mem_ok && fidx_ok) entry.kind = bmf_pkg::K_LOAD_U;
      end
      bmf_pkg::RT_LOAD_ITEM: begin
        if (iid_mem_ok && fidx_ok) entry.kind = bmf_pkg::K_LOAD_I;
      end
      default: entry.kind = bmf_pkg::K_REJECT;
    endcase
  end

  assign req_stall = q_full | clearing;
  assign push      = req_valid & ~req_stall;

endmodule

FILE: design/bmf_queue.sv
// ----------------------------------------------------------------------------
// bmf_queue
// Short FIFO of classified entries between the front and the back end.
// ----------------------------------------------------------------------------
module bmf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bmf_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output bmf_pkg::entry_t head
);

  localparam int D  = bmf_pkg::QUEUE_DEPTH;
  localparam int PW = (D > 1) ? $clog2(D) : 1;
  localparam int CW = $clog2(D + 1);

  bmf_pkg::entry_t slots [D];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(D));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(D - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(D - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

FILE: design/bmf_back.sv
// ----------------------------------------------------------------------------
// bmf_back
// Sequencer and datapath: holds bias and factor memories, forms the
// prediction factor by factor; a train steps both biases and each factor pair.
// ----------------------------------------------------------------------------
module bmf_back #(
  parameter int MAX_USERS   = bmf_pkg::MAX_USERS_DEF,
  parameter int MAX_ITEMS   = bmf_pkg::MAX_ITEMS_DEF,
  parameter int NUM_FACTORS = bmf_pkg::NUM_FACTORS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  bmf_pkg::cfg_t   cfg,
  input  logic            q_valid,
  input  bmf_pkg::entry_t q_entry,
  output logic            q_pop,
  output logic            clearing,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output bmf_pkg::rsp_t   rsp
);

  localparam int UW    = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
  localparam int IW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int FUN   = MAX_USERS * NUM_FACTORS;
  localparam int FIN   = MAX_ITEMS * NUM_FACTORS;
  localparam int FUW   = (FUN > 1) ? $clog2(FUN) : 1;
  localparam int FIW   = (FIN > 1) ? $clog2(FIN) : 1;
  localparam int KW    = (NUM_FACTORS > 1) ? $clog2(NUM_FACTORS) : 1;
  localparam int CLR_N = (MAX_USERS > MAX_ITEMS) ? MAX_USERS : MAX_ITEMS;
  localparam int CW    = (CLR_N > 1) ? $clog2(CLR_N) : 1;
  localparam logic [KW-1:0] K_LAST = KW'(NUM_FACTORS - 1);

  logic signed [31:0] ubias_mem [MAX_USERS];
  logic signed [31:0] ibias_mem [MAX_ITEMS];
  logic signed [31:0] ufac_mem  [FUN];
  logic signed [31:0] ifac_mem  [FIN];

  bmf_pkg::back_state_t state, state_next;
  bmf_pkg::entry_t      cur;
  bmf_pkg::rsp_t        res;
  logic [KW-1:0]        k;
  logic [CW-1:0]        clr_cnt;
  logic                 bias_ph;

  logic signed [47:0] acc;
  logic signed [63:0] prod;
  logic signed [31:0] ub, ib, mu, mv;
  logic signed [37:0] gu, gv;
  logic signed [32:0] ru, rv;
  logic signed [55:0] du, dv;
  logic [26:0]        pred;
  logic signed [29:0] err;

  logic signed [31:0] ubias_rd, ibias_rd, ufac_rd, ifac_rd;

  logic [UW-1:0]  uidx;
  logic [IW-1:0]  iidx;
  logic [FUW-1:0] uf_raddr, uf_ldaddr;
  logic [FIW-1:0] if_raddr, if_ldaddr;

  assign uidx      = cur.uid[UW-1:0];
  assign iidx      = cur.iid[IW-1:0];
  assign uf_raddr  = cur.ubase[FUW-1:0] + FUW'(k);
  assign if_raddr  = cur.ibase[FIW-1:0] + FIW'(k);
  assign uf_ldaddr = cur.ubase[FUW-1:0] + FUW'(cur.fidx);
  assign if_ldaddr = cur.ibase[FIW-1:0] + FIW'(cur.fidx);

  // write-side controls
  logic               ub_we, ib_we, uf_we, if_we;
  logic [UW-1:0]      ub_waddr;
  logic [IW-1:0]      ib_waddr;
  logic [FUW-1:0]     uf_waddr;
  logic [FIW-1:0]     if_waddr;
  logic signed [31:0] ub_wdata, ib_wdata, uf_wdata, if_wdata;

  // arithmetic
  logic signed [31:0] op_u, op_v;
  logic signed [61:0] eu_c, ev_c;
  logic signed [48:0] rpu_c, rpv_c;
  logic signed [38:0] dfu, dfv;
  logic signed [40:0] su, sv;
  logic signed [31:0] new_u, new_v;
  logic [26:0]        pred_c;

  always_comb begin
    op_u  = bias_ph ? ub : ufac_rd;
    op_v  = bias_ph ? ib : ifac_rd;
    eu_c  = err * op_v;
    ev_c  = err * op_u;
    rpu_c = $signed({1'b0, cfg.reg_strength}) * op_u;
    rpv_c = $signed({1'b0, cfg.reg_strength}) * op_v;
    dfu   = 39'(gu) - 39'(ru);
    dfv   = 39'(gv) - 39'(rv);
    su    = 41'(mu) + 41'(du >>> 16);
    sv    = 41'(mv) + 41'(dv >>> 16);
    new_u = bmf_pkg::sat32(su);
    new_v = bmf_pkg::sat32(sv);
    priority if (acc < bmf_pkg::PRED_LO) begin
      pred_c = 27'(bmf_pkg::PRED_LO);
    end else if (acc > bmf_pkg::PRED_HI) begin
      pred_c = 27'(bmf_pkg::PRED_HI);
    end else begin
      pred_c = acc[26:0];
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (ub_we) ubias_mem[ub_waddr] <= ub_wdata;
    ubias_rd <= ubias_mem[uidx];
  end

  always_ff @(posedge clk) begin
    if (ib_we) ibias_mem[ib_waddr] <= ib_wdata;
    ibias_rd <= ibias_mem[iidx];
  end

  always_ff @(posedge clk) begin
    if (uf_we) ufac_mem[uf_waddr] <= uf_wdata;
    ufac_rd <= ufac_mem[uf_raddr];
  end

  always_ff @(posedge clk) begin
    if (if_we) ifac_mem[if_waddr] <= if_wdata;
    ifac_rd <= ifac_mem[if_raddr];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bmf_pkg::B_CLEAR: if (clr_cnt == CW'(CLR_N - 1)) state_next = bmf_pkg::B_IDLE;
      bmf_pkg::B_IDLE: begin
        if (q_valid) begin
          unique case (q_entry.kind)
            bmf_pkg::K_LOAD_U, bmf_pkg::K_LOAD_I: state_next = bmf_pkg::B_LOAD;
            bmf_pkg::K_TRAIN, bmf_pkg::K_PREDICT: state_next = bmf_pkg::B_BRD;
            default:                              state_next = bmf_pkg::B_OUT;
          endcase
        end
      end
      bmf_pkg::B_LOAD: state_next = bmf_pkg::B_OUT;
      bmf_pkg::B_BRD:  state_next = bmf_pkg::B_BACC;
      bmf_pkg::B_BACC: state_next = bmf_pkg::B_DRD;
      bmf_pkg::B_DRD:  state_next = bmf_pkg::B_DMUL;
      bmf_pkg::B_DMUL: state_next = bmf_pkg::B_DACC;
      bmf_pkg::B_DACC: state_next = (k == K_LAST) ? bmf_pkg::B_PRED : bmf_pkg::B_DRD;
      bmf_pkg::B_PRED: begin
        state_next = (cur.kind == bmf_pkg::K_TRAIN) ? bmf_pkg::B_ERR : bmf_pkg::B_OUT;
      end
      bmf_pkg::B_ERR:  state_next = bmf_pkg::B_UM1;
      bmf_pkg::B_URD:  state_next = bmf_pkg::B_UM1;
      bmf_pkg::B_UM1:  state_next = bmf_pkg::B_UM2;
      bmf_pkg::B_UM2:  state_next = bmf_pkg::B_UWR;
      bmf_pkg::B_UWR: begin
        if (!bias_ph && k == K_LAST) state_next = bmf_pkg::B_OUT;
        else                         state_next = bmf_pkg::B_URD;
      end
      bmf_pkg::B_OUT: if (!rsp_stall) state_next = bmf_pkg::B_IDLE;
      default: state_next = bmf_pkg::B_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    q_pop    = 1'b0;
    ub_we    = 1'b0;
    ib_we    = 1'b0;
    uf_we    = 1'b0;
    if_we    = 1'b0;
    ub_waddr = uidx;
    ib_waddr = iidx;
    uf_waddr = uf_raddr;
    if_waddr = if_raddr;
    ub_wdata = new_u;
    ib_wdata = new_v;
    uf_wdata = new_u;
    if_wdata = new_v;
    unique case (state)
      bmf_pkg::B_CLEAR: begin
        ub_we    = 32'(clr_cnt) < 32'(MAX_USERS);
        ib_we    = 32'(clr_cnt) < 32'(MAX_ITEMS);
        ub_waddr = clr_cnt[UW-1:0];
        ib_waddr = clr_cnt[IW-1:0];
        ub_wdata = '0;
        ib_wdata = '0;
      end
      bmf_pkg::B_IDLE: q_pop = q_valid;
      bmf_pkg::B_LOAD: begin
        uf_we    = (cur.kind == bmf_pkg::K_LOAD_U);
        if_we    = (cur.kind == bmf_pkg::K_LOAD_I);
        uf_waddr = uf_ldaddr;
        if_waddr = if_ldaddr;
        uf_wdata = cur.fval;
        if_wdata = cur.fval;
      end
      bmf_pkg::B_UWR: begin
        ub_we = bias_ph;
        ib_we = bias_ph;
        uf_we = !bias_ph;
        if_we = !bias_ph;
      end
      default: ;
    endcase
  end

  assign clearing  = (state == bmf_pkg::B_CLEAR);
  assign rsp_valid = (state == bmf_pkg::B_OUT);
  assign rsp       = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= bmf_pkg::B_CLEAR;
      clr_cnt <= '0;
      k       <= '0;
      bias_ph <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        bmf_pkg::B_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        bmf_pkg::B_BACC:  k <= '0;
        bmf_pkg::B_DACC:  k <= k + 1'b1;
        bmf_pkg::B_ERR: begin
          k       <= '0;
          bias_ph <= 1'b1;
        end
        bmf_pkg::B_UWR: begin
          if (bias_ph) bias_ph <= 1'b0;
          else         k <= k + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      bmf_pkg::B_IDLE: begin
        if (q_valid) begin
          cur <= q_entry;
          res.prediction <= q_entry.rej_pred;
          res.status <= (q_entry.kind == bmf_pkg::K_REJECT) ? bmf_pkg::ST_OOR
                                                             : bmf_pkg::ST_LOADED;
        end
      end
      bmf_pkg::B_BACC: begin
        ub  <= ubias_rd;
        ib  <= ibias_rd;
        acc <= $signed({20'b0, cfg.global_avg, 12'b0}) + 48'(ubias_rd) + 48'(ibias_rd);
      end
      bmf_pkg::B_DMUL: prod <= ufac_rd * ifac_rd;
      bmf_pkg::B_DACC: acc <= acc + 48'(prod >>> 24);
      bmf_pkg::B_PRED: begin
        pred           <= pred_c;
        res.prediction <= 16'(pred_c >> 12);
        res.status     <= bmf_pkg::ST_DONE;
      end
      bmf_pkg::B_ERR: err <= $signed({2'b0, cur.rating, 12'b0}) - $signed({3'b0, pred});
      bmf_pkg::B_UM1: begin
        mu <= op_u;
        mv <= op_v;
        gu <= bias_ph ? 38'(err) : 38'(eu_c >>> 24);
        gv <= bias_ph ? 38'(err) : 38'(ev_c >>> 24);
        ru <= 33'(rpu_c >>> 16);
        rv <= 33'(rpv_c >>> 16);
      end
      bmf_pkg::B_UM2: begin
        du <= $signed({1'b0, cfg.learn_rate}) * dfu;
        dv <= $signed({1'b0, cfg.learn_rate}) * dfv;
      end
      default: ;
    endcase
  end

endmodule

FILE: design/biased_mf_sgd_update.sv
// ----------------------------------------------------------------------------
// biased_mf_sgd_update
// Biased matrix-factorization rating predictor with on-line SGD training.
// ----------------------------------------------------------------------------
// A single sequencer steps the factor memories one factor at a time and takes
// a new request only once it has finished the last one. A two-entry queue
// keeps taking requests while the back end is busy, until the queue is full.
// After reset the bias memories are cleared one entry per cycle, through
// max(MAX_USERS, MAX_ITEMS) entries, during which requests are stalled.
// ----------------------------------------------------------------------------
module biased_mf_sgd_update #(
  parameter int MAX_USERS   = bmf_pkg::MAX_USERS_DEF,
  parameter int MAX_ITEMS   = bmf_pkg::MAX_ITEMS_DEF,
  parameter int NUM_FACTORS = bmf_pkg::NUM_FACTORS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  bmf_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output bmf_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data
);

  bmf_pkg::cfg_t   cfg;
  bmf_pkg::entry_t f_entry, q_head;
  logic            push, q_full, q_valid, q_pop, clearing;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.global_avg   <= bmf_pkg::GLOBAL_AVG_RST;
      cfg.learn_rate   <= bmf_pkg::LEARN_RATE_RST;
      cfg.reg_strength <= bmf_pkg::REG_STRENGTH_RST;
      cfg.user_count   <= bmf_pkg::COUNT_RST;
      cfg.item_count   <= bmf_pkg::COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bmf_pkg::cfg_reg_t'(cfg_index))
        bmf_pkg::CFG_GLOBAL_AVG:   cfg.global_avg   <= cfg_data;
        bmf_pkg::CFG_LEARN_RATE:   cfg.learn_rate   <= cfg_data;
        bmf_pkg::CFG_REG_STRENGTH: cfg.reg_strength <= cfg_data;
        bmf_pkg::CFG_USER_COUNT:   cfg.user_count   <= cfg_data[10:0];
        bmf_pkg::CFG_ITEM_COUNT:   cfg.item_count   <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  bmf_front #(
    .MAX_USERS  (MAX_USERS),
    .MAX_ITEMS  (MAX_ITEMS),
    .NUM_FACTORS(NUM_FACTORS)
  ) u_front (
    .req_valid(req_valid),
    .req      (req),
    .req_stall(req_stall),
    .cfg      (cfg),
    .q_full   (q_full),
    .clearing (clearing),
    .push     (push),
    .entry    (f_entry)
  );

  bmf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(f_entry),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head      (q_head)
  );

  bmf_back #(
    .MAX_USERS  (MAX_USERS),
    .MAX_ITEMS  (MAX_ITEMS),
    .NUM_FACTORS(NUM_FACTORS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_entry  (q_head),
    .q_pop    (q_pop),
    .clearing (clearing),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  a_stall_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> req_stall)
    else $error("request taken while bias memories are clearing");

  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    !clearing |=> !clearing)
    else $error("bias clear restarted outside reset");

  a_pred_clamped: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == bmf_pkg::ST_DONE |->
      rsp.prediction >= 16'h1000 && rsp.prediction <= 16'h5000)
    else $error("completed prediction outside 1.0..5.0");

  a_no_out_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !rsp_valid && !q_pop)
    else $error("back end active during clear");

endmodule
